/* rtl/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine: request kinds, result
// status codes and the control word that drives the row of storage cells.
// ----------------------------------------------------------------------------
package olist_pkg;

  // Field widths of the stream words
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_VAL   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_IDX   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Cell row operations
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,   // keep contents
    OP_CMP  = 3'd1,   // load match flag from value compare
    OP_PFX  = 3'd2,   // one prefix-OR step over the match flags
    OP_INS  = 3'd3,   // open a gap at slot and write value there
    OP_DELP = 3'd4,   // close the gap at slot
    OP_DELV = 3'd5    // close the gap at the first matching cell
  } olist_op_t;

  typedef struct packed {
    olist_op_t           op;
    logic [VALUE_W-1:0]  value;
  } olist_ctl_t;

endpackage

/* rtl/olist_cell.sv */
// ----------------------------------------------------------------------------
// olist_cell
// One slot of the ordered list: holds a value and a match flag, and takes
// its neighbor's value when the row shifts for an insert or a delete.
// ----------------------------------------------------------------------------
module olist_cell #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0
) (
  input  logic                                     clk,
  input  olist_pkg::olist_ctl_t                    ctl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] slot,
  input  logic [(($clog2(DEPTH) > 1) ? $clog2($clog2(DEPTH)) : 1)-1:0] lvl,
  input  logic [$clog2(DEPTH+1)-1:0]               count,
  input  logic [olist_pkg::VALUE_W-1:0]            prev_data,
  input  logic [olist_pkg::VALUE_W-1:0]            next_data,
  input  logic [$clog2(DEPTH)-1:0]                 pfx_cand,
  output logic [olist_pkg::VALUE_W-1:0]            data_o,
  output logic                                     pfx_o
);
  import olist_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] data_r, data_nxt;
  logic               pfx_r, pfx_nxt;
  logic [IDX_W-1:0]   my_idx;
  logic               live;

  assign my_idx = IDX_W'(IDX);
  assign live   = CNT_W'(IDX) < count;

  // Pick the next value and match flag for this slot
  always_comb begin
    data_nxt = data_r;
    pfx_nxt  = pfx_r;
    unique case (ctl.op)
      OP_HOLD: ;
      OP_CMP:  pfx_nxt = live && (data_r == ctl.value);
      OP_PFX:  pfx_nxt = pfx_r | pfx_cand[lvl];
      OP_INS: begin
        if (my_idx == slot) data_nxt = ctl.value;
        else if (my_idx > slot) data_nxt = prev_data;
      end
      OP_DELP: begin
        if (my_idx >= slot) data_nxt = next_data;
      end
      OP_DELV: begin
        if (pfx_r) data_nxt = next_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pfx_r  <= pfx_nxt;
  end

  assign data_o = data_r;
  assign pfx_o  = pfx_r;

endmodule

/* rtl/ordered_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered list of up to DEPTH signed 32-bit values kept in a row of shift
// cells, serving insert, append, positional insert, search and deletes.
// ----------------------------------------------------------------------------
// One request is taken at a time; each returns one result word. Inserts,
// appends and deletes by index are decoded in the S_DEC state; once the
// output register is free, every cell shifts toward or away from its neighbor
// in the same cycle. Search and delete by value compare the value in all
// cells in parallel, then $clog2(DEPTH) prefix-OR steps across the row mark
// the first match, and the last cell's flag gives the found bit. A new
// request is accepted as soon as the previous one has been placed in the
// output register, even while that result waits for the consumer. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [38:32] position, [39] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [2] found, [9:3] count
);
  import olist_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LVLS  = $clog2(DEPTH);
  localparam int LVL_W = (LVLS > 1) ? $clog2(LVLS) : 1;
  localparam int PW    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_PFX  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [KIND_W-1:0]    req_kind_r;
  logic [VALUE_W-1:0]   req_value_r;
  logic [POS_W-1:0]     req_pos_r;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [15:0]          out_tdata_r, out_tdata_nxt;

  olist_ctl_t           ctl;
  logic [IDX_W-1:0]     slot;
  logic [VALUE_W-1:0]   cell_data [DEPTH];
  logic [DEPTH-1:0]     cell_pfx;
  logic [LVLS-1:0]      cand [DEPTH];

  logic                 in_fire, out_free, full;
  logic [PW-1:0]        pos_e, cnt_e, slot_e;
  logic [STATUS_W-1:0]  dec_status;
  olist_op_t            dec_op;
  logic                 found;
  logic [CNT_W+COUNT_W-1:0] cnt_wide;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_tvalid_r || out_tready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign pos_e    = PW'(req_pos_r);
  assign cnt_e    = PW'(count_r);
  assign found    = cell_pfx[DEPTH-1];

  // Latch the request word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind_r  <= in_tuser;
      req_value_r <= in_tdata[VALUE_W-1:0];
      req_pos_r   <= in_tdata[VALUE_W+POS_W-1:VALUE_W];
    end
  end

  // Decode positional requests into a row operation and a status
  always_comb begin
    dec_status = ST_OK;
    dec_op     = OP_HOLD;
    slot_e     = '0;
    unique case (req_kind_r)
      KIND_INS_FRONT: begin
        if (full) dec_status = ST_FULL;
        else dec_op = OP_INS;
      end
      KIND_APPEND: begin
        slot_e = cnt_e;
        if (full) dec_status = ST_FULL;
        else dec_op = OP_INS;
      end
      KIND_INS_POS: begin
        slot_e = pos_e - PW'(1);
        if (pos_e == '0 || pos_e > cnt_e + PW'(1)) dec_status = ST_BADPOS;
        else if (full) dec_status = ST_FULL;
        else dec_op = OP_INS;
      end
      KIND_DEL_IDX: begin
        slot_e = pos_e - PW'(1);
        if (count_r == '0) dec_status = ST_NONE;
        else if (pos_e == '0 || pos_e > cnt_e) dec_status = ST_BADPOS;
        else dec_op = OP_DELP;
      end
      default: ;
    endcase
  end

  assign slot = slot_e[IDX_W-1:0];

  // Sequence the request through the cell row
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lvl_nxt        = lvl_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ctl.op         = OP_HOLD;
    ctl.value      = req_value_r;
    cnt_wide       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (req_kind_r == KIND_SEARCH || req_kind_r == KIND_DEL_VAL) begin
          ctl.op    = OP_CMP;
          lvl_nxt   = '0;
          state_nxt = S_PFX;
        end else if (out_free) begin
          ctl.op = dec_op;
          if (dec_op == OP_INS) count_nxt = count_r + CNT_W'(1);
          else if (dec_op == OP_DELP) count_nxt = count_r - CNT_W'(1);
          cnt_wide       = {{COUNT_W{1'b0}}, count_nxt};
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0, cnt_wide[COUNT_W-1:0], 1'b0, dec_status};
          state_nxt      = S_IDLE;
        end
      end
      S_PFX: begin
        ctl.op  = OP_PFX;
        lvl_nxt = lvl_r + LVL_W'(1);
        if (lvl_r == LVL_W'(LVLS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (req_kind_r == KIND_DEL_VAL && found) begin
            ctl.op    = OP_DELV;
            count_nxt = count_r - CNT_W'(1);
          end
          cnt_wide       = {{COUNT_W{1'b0}}, count_nxt};
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0, cnt_wide[COUNT_W-1:0], found,
                            found ? ST_OK : ST_NONE};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      lvl_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      lvl_r        <= lvl_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Row of cells with neighbor links and prefix-OR taps
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] prev_d, next_d;

    for (genvar k = 0; k < LVLS; k++) begin : g_tap
      if (i >= (1 << k)) begin : g_link
        assign cand[i][k] = cell_pfx[i - (1 << k)];
      end else begin : g_edge
        assign cand[i][k] = 1'b0;
      end
    end

    if (i > 0) begin : g_prev
      assign prev_d = cell_data[i-1];
    end else begin : g_head
      assign prev_d = '0;
    end

    if (i < DEPTH - 1) begin : g_next
      assign next_d = cell_data[i+1];
    end else begin : g_tail
      assign next_d = '0;
    end

    olist_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .slot      (slot),
      .lvl       (lvl_r),
      .count     (count_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .pfx_cand  (cand[i]),
      .data_o    (cell_data[i]),
      .pfx_o     (cell_pfx[i])
    );
  end

endmodule

/* rtl/olist_chk.sv */
// ----------------------------------------------------------------------------
// olist_chk
// Port-level checks for the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module olist_chk #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import olist_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Drop the result channel on reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Found only comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == ST_OK)
    else $error("found flag with error status");

  // Full status only when the store holds DEPTH entries
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |-> out_tdata[9:3] == DEPTH_CNT)
    else $error("full status with spare room");

  // No new request is taken in the cycle right after one is accepted
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

endmodule

bind ordered_list_engine_unit olist_chk #(.DEPTH(DEPTH)) u_olist_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
